### design/dmtp_pkg.sv
// Shared types, constants and the duty lookup for the motor tach/PWM controller.
// No dependencies; dmtp_in_reg, dmtp_core and the top level import this package.
package dmtp_pkg;

   localparam int unsigned PeriodW = 16;
   localparam int unsigned LimitW  = 10;
   localparam int unsigned ScaleW  = 6;
   localparam int unsigned AdcW    = 10;
   localparam int unsigned RpmW    = 16;
   localparam int unsigned StepW   = 3;
   localparam int unsigned CsrIdxW = 2;
   localparam int unsigned CsrW    = 16;

   localparam logic [PeriodW-1:0] PeriodRst = 16'd1030;
   localparam logic [LimitW-1:0]  LimitRst  = 10'd999;
   localparam logic [ScaleW-1:0]  ScaleRst  = 6'd10;
   localparam logic [StepW-1:0]   StepRst   = 3'd3;
   localparam logic [StepW-1:0]   StepMin   = 3'd1;
   localparam logic [StepW-1:0]   StepMax   = 3'd6;

   typedef enum logic [2:0] {
      OP_TACH    = 3'd0,
      OP_WINDOW  = 3'd1,
      OP_STEP    = 3'd2,
      OP_DIR     = 3'd3,
      OP_APPLY   = 3'd4,
      OP_ADC     = 3'd5,
      OP_MODE    = 3'd6,
      OP_TICK    = 3'd7
   } op_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_PWM_PERIOD  = 2'd0,
      CSR_COUNT_LIMIT = 2'd1,
      CSR_RPM_SCALE   = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [PeriodW-1:0] pwm_period;
      logic [LimitW-1:0]  count_limit;
      logic [ScaleW-1:0]  rpm_scale;
   } cfg_type;

   typedef struct packed {
      op_type            op;
      logic              mode_digital;
      logic [AdcW-1:0]   adc_value;
   } event_type;

   typedef struct packed {
      logic [RpmW-1:0]   rpm_value;
      logic [AdcW-1:0]   pwm_compare;
      logic              pwm_level;
      logic              drive_a;
      logic              drive_b;
      logic              direction_flag;
      logic [StepW-1:0]  speed_step;
      logic              digital_mode_flag;
   } result_type;

   // Duty curve, one entry per speed step; bad steps use step 1.
   function automatic logic [AdcW-1:0] duty_of(input logic [StepW-1:0] step);
      logic [AdcW-1:0] duty;
      case (step)
         3'd2:    duty = 10'd249;
         3'd3:    duty = 10'd367;
         3'd4:    duty = 10'd495;
         3'd5:    duty = 10'd645;
         3'd6:    duty = 10'd901;
         default: duty = 10'd201;
      endcase
      return duty;
   endfunction

endpackage

### design/dmtp_if.sv
// Valid/ready channel interfaces for events in and status results out.
// Standalone; field widths follow the controller's event and result formats.
interface dmtp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic        mode_digital;
   logic [9:0]  adc_value;

   modport source (output valid, output op, output mode_digital, output adc_value,
                   input ready);
   modport sink   (input valid, input op, input mode_digital, input adc_value,
                   output ready);
endinterface

interface dmtp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] rpm_value;
   logic [9:0]  pwm_compare;
   logic        pwm_level;
   logic        drive_a;
   logic        drive_b;
   logic        direction_flag;
   logic [2:0]  speed_step;
   logic        digital_mode_flag;

   modport source (output valid, output rpm_value, output pwm_compare, output pwm_level,
                   output drive_a, output drive_b, output direction_flag,
                   output speed_step, output digital_mode_flag, input ready);
   modport sink   (input valid, input rpm_value, input pwm_compare, input pwm_level,
                   input drive_a, input drive_b, input direction_flag,
                   input speed_step, input digital_mode_flag, output ready);
endinterface

### design/dmtp_in_reg.sv
// Input register stage: captures one event per transfer and holds it on a stall.
// Depends on dmtp_pkg.
module dmtp_in_reg import dmtp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  event_type in_event,
   input  logic      advance,
   output logic      ev_valid,
   output event_type ev_data
);

   logic      vld_ff, vld_in;
   event_type data_ff;

   assign in_ready = !vld_ff || advance;
   assign vld_in   = in_ready ? in_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= in_event;
      end
   end

   assign ev_valid = vld_ff;
   assign ev_data  = data_ff;

endmodule

### design/dmtp_core.sv
// Controller state: tach counter, rpm, speed step, mode, direction, drive pins,
// PWM compare and counter. One event updates it per cycle while fire is high. Depends on dmtp_pkg.
module dmtp_core import dmtp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  event_type  ev,
   input  cfg_type    cfg,
   output result_type result
);

   logic [LimitW-1:0]  pulse_ff,   pulse_in;
   logic [RpmW-1:0]    rpm_ff,     rpm_in;
   logic [StepW-1:0]   step_ff,    step_in;
   logic               digital_ff, digital_in;
   logic               dir_ff,     dir_in;
   logic [1:0]         drive_ff,   drive_in;
   logic [AdcW-1:0]    compare_ff, compare_in;
   logic [AdcW-1:0]    duty_ff,    duty_in;
   logic [PeriodW-1:0] counter_ff, counter_in;
   logic               pwm_ff,     pwm_in;
   logic [LimitW-1:0]  clamped;

   assign clamped = (pulse_ff > cfg.count_limit) ? cfg.count_limit : pulse_ff;

   always_comb begin
      pulse_in   = pulse_ff;
      rpm_in     = rpm_ff;
      step_in    = step_ff;
      digital_in = digital_ff;
      dir_in     = dir_ff;
      drive_in   = drive_ff;
      compare_in = compare_ff;
      duty_in    = duty_ff;
      counter_in = counter_ff;
      pwm_in     = pwm_ff;
      case (ev.op)
         OP_TACH: begin
            if (pulse_ff < cfg.count_limit) begin
               pulse_in = pulse_ff + 1'b1;
            end
         end
         OP_WINDOW: begin
            rpm_in   = RpmW'({{(RpmW-LimitW){1'b0}}, clamped} *
                             {{(RpmW-ScaleW){1'b0}}, cfg.rpm_scale});
            pulse_in = '0;
         end
         OP_STEP: begin
            if (digital_ff) begin
               step_in = (step_ff >= StepMax) ? StepMin : step_ff + 1'b1;
            end
         end
         OP_DIR: begin
            dir_in = !dir_ff;
         end
         OP_APPLY: begin
            drive_in = dir_ff ? 2'b10 : 2'b01;
            if (digital_ff) begin
               duty_in    = duty_of(step_ff);
               compare_in = duty_in;
            end
         end
         OP_ADC: begin
            if (!digital_ff) begin
               compare_in = ev.adc_value;
            end
         end
         OP_MODE: begin
            digital_in = ev.mode_digital;
            if (ev.mode_digital) begin
               compare_in = duty_ff;
            end
         end
         OP_TICK: begin
            counter_in = (counter_ff >= cfg.pwm_period) ? '0 : counter_ff + 1'b1;
            // set at period, clear at compare; clear wins
            if (counter_in == cfg.pwm_period) begin
               pwm_in = 1'b1;
            end
            if (counter_in == {{(PeriodW-AdcW){1'b0}}, compare_ff}) begin
               pwm_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff   <= '0;
         rpm_ff     <= '0;
         step_ff    <= StepRst;
         digital_ff <= 1'b1;
         dir_ff     <= 1'b0;
         drive_ff   <= '0;
         compare_ff <= '0;
         duty_ff    <= '0;
         counter_ff <= '0;
         pwm_ff     <= 1'b0;
      end else if (fire) begin
         pulse_ff   <= pulse_in;
         rpm_ff     <= rpm_in;
         step_ff    <= step_in;
         digital_ff <= digital_in;
         dir_ff     <= dir_in;
         drive_ff   <= drive_in;
         compare_ff <= compare_in;
         duty_ff    <= duty_in;
         counter_ff <= counter_in;
         pwm_ff     <= pwm_in;
      end
   end

   // result shows the state after this event
   assign result.rpm_value         = rpm_in;
   assign result.pwm_compare       = compare_in;
   assign result.pwm_level         = pwm_in;
   assign result.drive_a           = drive_in[0];
   assign result.drive_b           = drive_in[1];
   assign result.direction_flag    = dir_in;
   assign result.speed_step        = step_in;
   assign result.digital_mode_flag = digital_in;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff >= StepMin && step_ff <= StepMax)
      else $error("speed step left its range");

   a_drive_exclusive: assert property (@(posedge clock) disable iff (reset)
      drive_ff != 2'b11)
      else $error("both drive pins active");

   a_apply_drives: assert property (@(posedge clock) disable iff (reset)
      fire && ev.op == OP_APPLY |=> drive_ff[0] == !$past(dir_ff) && drive_ff[1] == $past(dir_ff))
      else $error("drive pins do not follow direction on apply");

   a_window_clears: assert property (@(posedge clock) disable iff (reset)
      fire && ev.op == OP_WINDOW |=> pulse_ff == '0)
      else $error("pulse count not cleared at window end");

endmodule

### design/dc_motor_tach_and_pwm_control.sv
// Top level of the DC motor tach and PWM controller: config registers, pipeline
// control and result register. Depends on dmtp_pkg, dmtp_if, dmtp_in_reg, dmtp_core.
//
// Usage:
//   req_if carries one event per transfer: op (tach pulse, window end, step
//   button, direction button, apply, adc sample, mode poll, pwm tick), the mode
//   switch level and an adc sample. rsp_if returns exactly one status item per
//   event: rpm, PWM compare, PWM pin level, drive pins, direction, speed step
//   and mode, all as they stand after that event.
//   csr_wr_en/csr_index/csr_wdata write pwm_period (0), count_limit (1) and
//   rpm_scale (2); other indexes are dropped. Write only while the block is idle.
//   Pipeline: an event passes the input register, then the result register,
//   before its result is presented on rsp_if. Throughput: one event per cycle
//   while the receiver is ready; each event is a single register update of the
//   controller state.
//   Reset (synchronous, active high) empties both stages and restores the
//   register defaults: period 1030, limit 999, scale 10, step 3, digital mode.
//   When the receiver stalls, the result register holds its item and an empty input
//   register still takes one more event; after that req_if.ready drops.
module dc_motor_tach_and_pwm_control import dmtp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   dmtp_req_if.sink           req_if,
   dmtp_rsp_if.source         rsp_if,
   input  logic               csr_wr_en,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrW-1:0]    csr_wdata
);

   cfg_type    cfg_ff;
   event_type  in_event, ev;
   result_type result, rsp_ff;
   logic       ev_valid, advance, fire, rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period  <= PeriodRst;
         cfg_ff.count_limit <= LimitRst;
         cfg_ff.rpm_scale   <= ScaleRst;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PWM_PERIOD:  cfg_ff.pwm_period  <= csr_wdata[PeriodW-1:0];
            CSR_COUNT_LIMIT: cfg_ff.count_limit <= csr_wdata[LimitW-1:0];
            CSR_RPM_SCALE:   cfg_ff.rpm_scale   <= csr_wdata[ScaleW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign in_event.op           = op_type'(req_if.op);
   assign in_event.mode_digital = req_if.mode_digital;
   assign in_event.adc_value    = req_if.adc_value;

   // advance when the result register is empty or being drained
   assign advance = !rsp_vld_ff || rsp_if.ready;
   assign fire    = ev_valid && advance;

   dmtp_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_ready (req_if.ready),
      .in_event (in_event),
      .advance  (advance),
      .ev_valid (ev_valid),
      .ev_data  (ev)
   );

   dmtp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .ev     (ev),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= ev_valid;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_if.valid             = rsp_vld_ff;
   assign rsp_if.rpm_value         = rsp_ff.rpm_value;
   assign rsp_if.pwm_compare       = rsp_ff.pwm_compare;
   assign rsp_if.pwm_level         = rsp_ff.pwm_level;
   assign rsp_if.drive_a           = rsp_ff.drive_a;
   assign rsp_if.drive_b           = rsp_ff.drive_b;
   assign rsp_if.direction_flag    = rsp_ff.direction_flag;
   assign rsp_if.speed_step        = rsp_ff.speed_step;
   assign rsp_if.digital_mode_flag = rsp_ff.digital_mode_flag;

endmodule
